FILE: src/srx_pkg.sv
`default_nettype none
package srx_pkg;

	// frame geometry
	localparam int FRAME_BYTES = 64;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

	// sync marker that opens a frame
	localparam logic [7:0] SYNC_BYTE = 8'hFF;

	// result item kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_ERR  = 1'b1;

	// input queue between front and back (power of two)
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// head of the input queue as seen by the back end
	typedef struct packed {
		logic       vld;
		logic       is_sync;
		logic [7:0] data;
	} rx_item_t;

endpackage
`default_nettype wire

FILE: src/srx_front.sv
`default_nettype none
module srx_front
	import srx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_stall,
	input  wire logic [7:0] rx_byte,
	output rx_item_t        head,
	input  wire logic       pop
);

	logic [7:0]     data_q [QDEPTH];
	logic           sync_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           push;
	logic           do_pop;

	// queue full stalls the line side
	assign rx_stall = (cnt_q == QCW'(QDEPTH));
	assign push     = rx_valid && !rx_stall;
	assign do_pop   = pop && (cnt_q != '0);

	// head of queue, with the sync classification made on entry
	assign head.vld     = (cnt_q != '0);
	assign head.is_sync = sync_q[rd_ptr_q];
	assign head.data    = data_q[rd_ptr_q];

	// payload storage
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= rx_byte;
			sync_q[wr_ptr_q] <= (rx_byte == SYNC_BYTE);
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + QCW'(1);
			else if (!push && do_pop)
				cnt_q <= cnt_q - QCW'(1);
		end
	end

endmodule
`default_nettype wire

FILE: src/srx_back.sv
`default_nettype none
module srx_back
	import srx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  rx_item_t        head,
	output logic            pop,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic            kind,
	output logic [7:0]      frame_byte,
	output logic [7:0]      byte_index,
	output logic            last
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN    = 3'd1;
	localparam logic [2:0] ST_DECIDE  = 3'd2;
	localparam logic [2:0] ST_EMIT_RD = 3'd3;
	localparam logic [2:0] ST_EMIT_LD = 3'd4;
	localparam logic [2:0] ST_ERR     = 3'd5;
	localparam logic [2:0] ST_COPY_RD = 3'd6;
	localparam logic [2:0] ST_COPY_WR = 3'd7;

	logic [7:0]       mem [FRAME_BYTES];
	logic [7:0]       rd_data_q;
	logic [IDX_W-1:0] mem_raddr;
	logic [IDX_W-1:0] mem_waddr;
	logic [7:0]       mem_wdata;
	logic             mem_we;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] scan_addr_q;
	logic [IDX_W-1:0] idx_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [7:0]       sum_q;
	logic [7:0]       byte1_q;
	logic             ff_found_q;
	logic [IDX_W-1:0] ff_pos_q;

	logic             out_valid_q;
	logic             out_kind_q;
	logic [7:0]       out_byte_q;
	logic [7:0]       out_index_q;
	logic             out_last_q;

	logic             slot_free;
	logic             take_byte;

	assign slot_free = !out_valid_q || !res_stall;

	// bytes are only taken while no frame is being checked or emitted
	assign pop       = (state_q == ST_IDLE) && head.vld;
	assign take_byte = pop && ((fill_q != '0) || head.is_sync);

	// memory address and write selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_q[IDX_W-1:0];
		mem_wdata = head.data;
		case (state_q)
			ST_IDLE:    mem_we = take_byte;
			ST_COPY_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = rd_data_q;
			end
			default:    mem_we = 1'b0;
		endcase
	end

	// read address stays on the emitted byte while the output slot is busy
	always_comb begin
		case (state_q)
			ST_EMIT_RD: mem_raddr = idx_q;
			ST_EMIT_LD: mem_raddr = idx_q;
			ST_COPY_RD: mem_raddr = ff_pos_q + idx_q;
			default:    mem_raddr = scan_addr_q;
		endcase
	end

	// frame store, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_data_q <= mem[mem_raddr];
	end

	// scan pipeline: checksum, byte 1 and first sync after position 0
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_addr_q;
		if (state_q == ST_IDLE) begin
			sum_q      <= '0;
			ff_found_q <= 1'b0;
			ff_pos_q   <= '0;
		end else if (rd_vld_s1) begin
			if (rd_idx_s1 >= IDX_W'(2))
				sum_q <= sum_q + rd_data_q;
			if (rd_idx_s1 == IDX_W'(1))
				byte1_q <= rd_data_q;
			if ((rd_idx_s1 != '0) && (rd_data_q == SYNC_BYTE) && !ff_found_q) begin
				ff_found_q <= 1'b1;
				ff_pos_q   <= rd_idx_s1;
			end
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			scan_addr_q <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					scan_addr_q <= '0;
					if (take_byte) begin
						if (fill_q == CNT_W'(FRAME_BYTES - 1))
							state_q <= ST_SCAN;
						else
							fill_q <= fill_q + CNT_W'(1);
					end
				end
				ST_SCAN: begin
					scan_addr_q <= scan_addr_q + IDX_W'(1);
					if (scan_addr_q == IDX_W'(FRAME_BYTES - 1))
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					idx_q <= '0;
					if (!rd_vld_s1)
						state_q <= (sum_q == byte1_q) ? ST_EMIT_RD : ST_ERR;
				end
				ST_EMIT_RD: state_q <= ST_EMIT_LD;
				ST_EMIT_LD: begin
					if (slot_free) begin
						if (idx_q == IDX_W'(FRAME_BYTES - 1)) begin
							fill_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_ERR: begin
					if (slot_free) begin
						if (ff_found_q) begin
							fill_q  <= CNT_W'(FRAME_BYTES) - CNT_W'(ff_pos_q);
							state_q <= ST_COPY_RD;
						end else begin
							fill_q  <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_COPY_RD: state_q <= ST_COPY_WR;
				ST_COPY_WR: begin
					if (CNT_W'(idx_q) + CNT_W'(1) == fill_q) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_COPY_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (slot_free && ((state_q == ST_EMIT_LD) || (state_q == ST_ERR)))
			out_valid_q <= 1'b1;
		else if (!res_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (slot_free && (state_q == ST_EMIT_LD)) begin
			out_kind_q  <= KIND_DATA;
			out_byte_q  <= rd_data_q;
			out_index_q <= 8'(idx_q);
			out_last_q  <= (idx_q == IDX_W'(FRAME_BYTES - 1));
		end else if (slot_free && (state_q == ST_ERR)) begin
			out_kind_q  <= KIND_ERR;
			out_byte_q  <= '0;
			out_index_q <= '0;
			out_last_q  <= 1'b1;
		end
	end

	assign res_valid  = out_valid_q;
	assign kind       = out_kind_q;
	assign frame_byte = out_byte_q;
	assign byte_index = out_index_q;
	assign last       = out_last_q;

	// store never holds a full frame between bytes
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CNT_W'(FRAME_BYTES))
		else $error("fill count reached frame length");

	// an error item is always a lone, zeroed, last item
	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == KIND_ERR)) |->
			(out_last_q && (out_byte_q == '0) && (out_index_q == '0)))
		else $error("malformed error item");

	// queue is drained only while idle
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE))
		else $error("byte taken during frame processing");

	// resync copy stays inside the kept tail
	a_copy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY_WR) |-> (CNT_W'(idx_q) < fill_q))
		else $error("resync copy overran");

	// a frame scan starts only after the last byte of a frame was stored
	a_scan_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_SCAN) |-> $past(take_byte))
		else $error("scan without a completed frame");

endmodule
`default_nettype wire

FILE: src/sync_frame_receiver_with_resync.sv
// Sync-byte frame receiver with additive checksum and resync.
//
// Input channel: rx_byte with rx_valid / rx_stall; a transfer happens on a
// clock edge with rx_valid high and rx_stall low. Bytes enter a 4-entry
// queue at one per cycle; rx_stall rises only when that queue is full.
// Output channel: kind, frame_byte, byte_index, last with res_valid /
// res_stall, from an output register.
// A byte that does not complete a frame is popped from the queue and, unless
// it is dropped while no sync byte has opened a frame, written to the frame
// store. The byte that completes a frame starts a scan of the frame store
// (one read port) that checks the checksum, then a good frame streams out
// byte by byte (read, then load the output register). A bad frame gives one
// error item; if a sync byte follows position 0, the resync copy then moves
// the tail from that byte to the front, one read and one write per byte.
// Reset (arst_n low) empties the queue, the output register and the frame
// store's fill count; the store contents themselves are not cleared.
// While res_stall is high the output register holds its item, the back end
// waits, and once the queue fills rx_stall goes high; no item is lost.
`default_nettype none
module sync_frame_receiver_with_resync
	import srx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_stall,
	input  wire logic [7:0] rx_byte,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic            kind,
	output logic [7:0]      frame_byte,
	output logic [7:0]      byte_index,
	output logic            last
);

	rx_item_t head;
	logic     pop;

	// receive queue and sync classification
	srx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.head     (head),
		.pop      (pop)
	);

	// frame store, checksum, emit and resync
	srx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.kind       (kind),
		.frame_byte (frame_byte),
		.byte_index (byte_index),
		.last       (last)
	);

endmodule
`default_nettype wire
